FILE: rtl/rcr_pkg.sv
// Package for the raycast column renderer: shared constants, codes and structs.
// No dependencies; every other file of the block but rcr_if imports it.
package rcr_pkg;

  // Default sizes
  localparam int MAP_CELLS_DEF   = 16;
  localparam int SCREEN_ROWS_DEF = 480;
  localparam int MARCH_STEPS_DEF = 4096;
  localparam int QUEUE_DEPTH     = 2;

  // Fixed-point constants
  localparam int RANGE_Q12  = 81920;
  localparam int FRAC_LOW   = 41;
  localparam int FRAC_HIGH  = 4055;
  localparam int EPS_Q12    = 41;
  localparam int SHADE_DEN  = 20480;
  localparam int SPAN_SCALE = 6144;
  localparam int SIN_C1     = 25736;
  localparam int SIN_C3     = 10583;
  localparam int SIN_C5     = 1231;

  // Base colors for the two sides
  localparam int COL_R0 = 255;
  localparam int COL_G0 = 100;
  localparam int COL_R1 = 180;
  localparam int COL_G1 = 70;

  // Divider widths
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 17;

  typedef enum logic {OP_WRITE_ROW = 1'b0, OP_CAST = 1'b1} opcode_t;

  typedef enum logic [1:0] {
    CFG_POS_X      = 2'd0,
    CFG_POS_Y      = 2'd1,
    CFG_VIEW_ANGLE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] view_angle;
  } cfg_t;

  typedef struct packed {
    logic        is_cast;
    logic [3:0]  row;
    logic [15:0] bits;
    logic [9:0]  column;
    logic [11:0] angle;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  column;
    logic        wall_hit;
    logic        side;
    logic [16:0] distance;
    logic [8:0]  span_start;
    logic [8:0]  span_end;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/rcr_if.sv
// Channel interfaces of the raycast column renderer: input, result and config.
// Depends on no other file.
interface rcr_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  row_index;
  logic [15:0] row_bits;
  logic [9:0]  column;
  logic [11:0] cast_angle;
  modport source(output valid, opcode, row_index, row_bits, column, cast_angle, input ready);
  modport sink(input valid, opcode, row_index, row_bits, column, cast_angle, output ready);
endinterface

interface rcr_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  column;
  logic        wall_hit;
  logic        side;
  logic [16:0] distance;
  logic [8:0]  span_start;
  logic [8:0]  span_end;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  modport source(output valid, column, wall_hit, side, distance, span_start, span_end,
                 red, green, blue, input ready);
  modport sink(input valid, column, wall_hit, side, distance, span_start, span_end,
               red, green, blue, output ready);
endinterface

interface rcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [15:0] data;
  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

FILE: rtl/rcr_front.sv
// Front stage: accepts input beats, drops writes to rows outside the map, and
// hands commands to the queue. Depends on rcr_pkg and rcr_if.
module rcr_front #(
  parameter int MAP_CELLS = rcr_pkg::MAP_CELLS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rcr_in_if.sink        in_s,
  output rcr_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_ready
);
  import rcr_pkg::*;

  logic v_r;
  cmd_t data_r;
  logic accept;
  logic keep;

  assign in_s.ready = !v_r || q_ready;
  assign accept     = in_s.valid && in_s.ready;
  // casts always go on; row writes only when the row exists
  assign keep = (in_s.opcode == OP_CAST) || (32'(in_s.row_index) < MAP_CELLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= keep;
    end else if (q_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r.is_cast <= (in_s.opcode == OP_CAST);
      data_r.row     <= in_s.row_index;
      data_r.bits    <= in_s.row_bits;
      data_r.column  <= in_s.column;
      data_r.angle   <= in_s.cast_angle;
    end
  end

  assign q_valid = v_r;
  assign q_data  = data_r;
endmodule

FILE: rtl/rcr_fifo.sv
// Short command queue between front and back stages.
// Depends on rcr_pkg.
module rcr_fifo #(
  parameter int DEPTH = rcr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rcr_pkg::cmd_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output rcr_pkg::cmd_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import rcr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             ent_r [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end
endmodule

FILE: rtl/rcr_div.sv
// Restoring divider, one quotient bit per cycle, shared by span and shading.
// Depends on rcr_pkg.
module rcr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rcr_pkg::div_req_t req,
  output rcr_pkg::div_rsp_t rsp
);
  import rcr_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DEN_W'(shifted - {1'b0, den_r}) : shifted[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

FILE: rtl/rcr_back.sv
// Back stage: holds the wall map, runs trig, marches the ray, then divides out
// span and shading. Depends on rcr_pkg and rcr_div.
module rcr_back #(
  parameter int MAP_CELLS   = rcr_pkg::MAP_CELLS_DEF,
  parameter int SCREEN_ROWS = rcr_pkg::SCREEN_ROWS_DEF,
  parameter int MARCH_STEPS = rcr_pkg::MARCH_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rcr_pkg::cfg_t    cfg,
  input  rcr_pkg::cmd_t    q_data,
  input  logic             q_valid,
  output logic             q_ready,
  output rcr_pkg::result_t res,
  output logic             res_valid,
  input  logic             res_ready
);
  import rcr_pkg::*;

  localparam int ROW_W = $clog2(MAP_CELLS);
  localparam int CNT_W = $clog2(MARCH_STEPS + 1);
  localparam int STEP  = RANGE_Q12 / MARCH_STEPS;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_STEP, S_MARCH, S_PROD, S_DIV_GO, S_DIV_WAIT, S_SPAN, S_EMIT
  } state_t;

  state_t state_r;
  cmd_t   cmd_r;
  logic [15:0] map_r [MAP_CELLS];
  logic [15:0] rd_r;

  // trig sequencer
  logic [1:0]  ti_r;
  logic [1:0]  tph_r;
  logic [10:0] t2_r;
  logic [13:0] inner_r;
  logic [14:0] mid_r;
  logic signed [15:0] cos_r;
  logic signed [15:0] sin_r;
  logic signed [15:0] rel_r;
  logic [11:0] ang;
  logic [10:0] t_val;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] prod_u;
  logic [14:0] qv;
  logic signed [15:0] qv_s;

  // march
  logic signed [32:0] dx_r;
  logic signed [32:0] dy_r;
  logic signed [32:0] rx_r;
  logic signed [32:0] ry_r;
  logic [16:0]        dist_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               s1_v_r;
  logic               chk_v_r;
  logic               chk_last_r;
  logic               chk_oob_r;
  logic [5:0]         chk_cx_r;
  logic [11:0]        chk_frac_r;
  logic [16:0]        chk_dist_r;
  logic               s1_oob;
  logic               chk_wall;
  logic signed [25:0] dx_p;
  logic signed [25:0] dy_p;

  // finish
  logic               hit_r;
  logic               side_r;
  logic [16:0]        d_r;
  logic [1:0]         dv_r;
  logic [18:0]        h_r;
  logic [7:0]         red_r;
  logic [7:0]         green_r;
  logic [7:0]         blue_r;
  result_t            res_r;
  logic signed [33:0] prod_s;
  logic signed [20:0] diff;
  logic signed [20:0] half;
  logic signed [20:0] endv;
  logic signed [20:0] start_c;
  logic signed [20:0] end_c;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic mem_we;

  rcr_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  // angle and folded quarter-turn argument for the current trig pass
  always_comb begin
    unique case (ti_r)
      2'd0:    ang = cmd_r.angle + 12'd1024;
      2'd1:    ang = cmd_r.angle;
      default: ang = cmd_r.angle - cfg.view_angle + 12'd1024;
    endcase
    t_val = ang[10] ? (11'd1024 - {1'b0, ang[9:0]}) : {1'b0, ang[9:0]};
  end

  // shared multiplier of the polynomial
  always_comb begin
    unique case (tph_r)
      2'd0: begin mul_a = {5'b0, t_val}; mul_b = {5'b0, t_val}; end
      2'd1: begin mul_a = {5'b0, t2_r};  mul_b = 16'(SIN_C5); end
      2'd2: begin mul_a = {5'b0, t2_r};  mul_b = {2'b0, inner_r}; end
      default: begin mul_a = {5'b0, t_val}; mul_b = {1'b0, mid_r}; end
    endcase
    prod_u = mul_a * mul_b;
    qv     = prod_u[24:10];
    qv_s   = ang[11] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
  end

  // step vector and cell classification
  assign dx_p = cos_r * $signed(10'(STEP));
  assign dy_p = sin_r * $signed(10'(STEP));
  assign s1_oob = rx_r[32] || ry_r[32] || ({1'b0, rx_r[31:26]} >= 7'(MAP_CELLS))
                  || ({1'b0, ry_r[31:26]} >= 7'(MAP_CELLS));
  assign chk_wall = chk_oob_r || ((chk_cx_r < 6'd16) && rd_r[chk_cx_r[3:0]]);

  // span arithmetic, truncating halving
  always_comb begin
    diff    = $signed(21'(SCREEN_ROWS)) - $signed({2'b0, h_r});
    half    = (diff + ((diff < 0) ? 21'sd1 : 21'sd0)) >>> 1;
    endv    = half + $signed({2'b0, h_r});
    start_c = (half < 0) ? 21'sd0 : half;
    end_c   = (endv >= $signed(21'(SCREEN_ROWS))) ? $signed(21'(SCREEN_ROWS - 1)) : endv;
  end

  assign prod_s = $signed({1'b0, dist_r}) * rel_r;

  // divider requests
  always_comb begin
    div_req.start = (state_r == S_DIV_GO);
    unique case (dv_r)
      2'd0: begin
        div_req.num = DIV_NUM_W'(SCREEN_ROWS * SPAN_SCALE);
        div_req.den = d_r + DIV_DEN_W'(EPS_Q12);
      end
      2'd1: begin
        div_req.num = side_r ? DIV_NUM_W'(COL_R1 * SHADE_DEN) : DIV_NUM_W'(COL_R0 * SHADE_DEN);
        div_req.den = d_r + DIV_DEN_W'(SHADE_DEN);
      end
      default: begin
        div_req.num = side_r ? DIV_NUM_W'(COL_G1 * SHADE_DEN) : DIV_NUM_W'(COL_G0 * SHADE_DEN);
        div_req.den = d_r + DIV_DEN_W'(SHADE_DEN);
      end
    endcase
  end

  assign q_ready = (state_r == S_IDLE);
  assign mem_we  = (state_r == S_IDLE) && q_valid && !q_data.is_cast;

  // wall map: one write port, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_r[ROW_W'(q_data.row)] <= q_data.bits;
    end
    rd_r <= map_r[ry_r[26 +: ROW_W]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      s1_v_r  <= 1'b0;
      chk_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && q_data.is_cast) begin
            cmd_r   <= q_data;
            ti_r    <= 2'd0;
            tph_r   <= 2'd0;
            state_r <= S_TRIG;
          end
        end
        S_TRIG: begin
          tph_r <= tph_r + 2'd1;
          unique case (tph_r)
            2'd0: t2_r    <= prod_u[20:10];
            2'd1: inner_r <= 14'(SIN_C3) - prod_u[23:10];
            2'd2: mid_r   <= 15'(SIN_C1) - prod_u[24:10];
            default: begin
              unique case (ti_r)
                2'd0:    cos_r <= qv_s;
                2'd1:    sin_r <= qv_s;
                default: rel_r <= qv_s;
              endcase
              ti_r <= ti_r + 2'd1;
              if (ti_r == 2'd2) begin
                state_r <= S_STEP;
              end
            end
          endcase
        end
        S_STEP: begin
          dx_r    <= 33'(dx_p);
          dy_r    <= 33'(dy_p);
          rx_r    <= 33'({cfg.pos_x, 14'b0});
          ry_r    <= 33'({cfg.pos_y, 14'b0});
          dist_r  <= '0;
          cnt_r   <= '0;
          s1_v_r  <= 1'b0;
          chk_v_r <= 1'b0;
          state_r <= S_MARCH;
        end
        S_MARCH: begin
          if (chk_v_r && (chk_wall || chk_last_r)) begin
            hit_r   <= chk_wall;
            side_r  <= chk_wall && ((chk_frac_r < 12'(FRAC_LOW)) ||
                                    (chk_frac_r > 12'(FRAC_HIGH)));
            dist_r  <= chk_dist_r;
            s1_v_r  <= 1'b0;
            chk_v_r <= 1'b0;
            state_r <= S_PROD;
          end else begin
            // check the position issued last cycle, advance the next one
            chk_v_r    <= s1_v_r;
            chk_last_r <= (cnt_r == CNT_W'(MARCH_STEPS));
            chk_oob_r  <= s1_oob;
            chk_cx_r   <= rx_r[31:26];
            chk_frac_r <= rx_r[32] ? 12'd0 : rx_r[25:14];
            chk_dist_r <= dist_r;
            if (cnt_r != CNT_W'(MARCH_STEPS)) begin
              rx_r   <= rx_r + dx_r;
              ry_r   <= ry_r + dy_r;
              dist_r <= dist_r + 17'(STEP);
              cnt_r  <= cnt_r + 1'b1;
              s1_v_r <= 1'b1;
            end else begin
              s1_v_r <= 1'b0;
            end
          end
        end
        S_PROD: begin
          d_r     <= (prod_s[33] || prod_s == '0) ? 17'd0 : prod_s[30:14];
          dv_r    <= 2'd0;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (dv_r)
              2'd0:    h_r     <= div_rsp.quo[18:0];
              2'd1:    red_r   <= div_rsp.quo[7:0];
              2'd2:    green_r <= div_rsp.quo[7:0];
              default: blue_r  <= div_rsp.quo[7:0];
            endcase
            dv_r    <= dv_r + 2'd1;
            state_r <= (dv_r == 2'd3) ? S_SPAN : S_DIV_GO;
          end
        end
        S_SPAN: begin
          res_r.column     <= cmd_r.column;
          res_r.wall_hit   <= hit_r;
          res_r.side       <= side_r;
          res_r.distance   <= d_r;
          res_r.span_start <= start_c[8:0];
          res_r.span_end   <= end_c[8:0];
          res_r.red        <= red_r;
          res_r.green      <= green_r;
          res_r.blue       <= blue_r;
          state_r          <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res       = res_r;
  assign res_valid = (state_r == S_EMIT);

  a_no_div_in_march: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARCH) |-> !div_rsp.busy) else $error("divider busy during march");
  a_last_ends_march: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARCH && chk_v_r && chk_last_r) |=> (state_r == S_PROD))
    else $error("march ran past its last step");
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !res_ready) |=> (state_r == S_EMIT && $stable(res_r)))
    else $error("result dropped while stalled");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE)) else $error("map written during a cast");
endmodule

FILE: rtl/raycast_column_renderer.sv
// Top level of the raycast column renderer: config registers, front, queue,
// back and result register. Depends on rcr_pkg, rcr_if and all rcr_ modules.
//
// Use: load the wall map with write beats (opcode 0, one 16-bit row each),
// set pos_x, pos_y and view_angle through cfg_s (indexes 0..2, taken at once,
// cfg_s.ready is always high), then send cast beats (opcode 1), one per column.
// Each cast gives one result beat on out_m; writes give none.
// A cast evaluates a sine/cosine polynomial on one shared multiplier, marches
// the ray one step per cycle (up to MARCH_STEPS, stopping at the first wall)
// through a registered map-read pipeline, then runs four divisions (span
// height and three shaded colors) on one serial divider.
// Casts run one at a time in the back stage; a two-entry queue and the front
// register keep taking beats meanwhile.
// Reset (rst_n low, synchronous) clears control and config registers; the
// map is undefined until written. When out_m.ready is low the result is held
// in the output register, the back stage waits after its next cast, and the
// queue then fills and drops in_s.ready.
module raycast_column_renderer #(
  parameter int MAP_CELLS   = rcr_pkg::MAP_CELLS_DEF,
  parameter int SCREEN_ROWS = rcr_pkg::SCREEN_ROWS_DEF,
  parameter int MARCH_STEPS = rcr_pkg::MARCH_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rcr_in_if.sink     in_s,
  rcr_out_if.source  out_m,
  rcr_cfg_if.sink    cfg_s
);
  import rcr_pkg::*;

  cfg_t    cfg_r;
  cmd_t    f_data;
  logic    f_valid;
  logic    f_ready;
  cmd_t    b_data;
  logic    b_valid;
  logic    b_ready;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    out_v_r;
  result_t out_r;

  // configuration registers
  assign cfg_s.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.idx)
        CFG_POS_X:      cfg_r.pos_x      <= cfg_s.data;
        CFG_POS_Y:      cfg_r.pos_y      <= cfg_s.data;
        CFG_VIEW_ANGLE: cfg_r.view_angle <= cfg_s.data[11:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  rcr_front #(.MAP_CELLS(MAP_CELLS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_s(in_s),
    .q_data(f_data), .q_valid(f_valid), .q_ready(f_ready)
  );

  rcr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_data(f_data), .push_valid(f_valid), .push_ready(f_ready),
    .pop_data(b_data), .pop_valid(b_valid), .pop_ready(b_ready)
  );

  rcr_back #(
    .MAP_CELLS(MAP_CELLS), .SCREEN_ROWS(SCREEN_ROWS), .MARCH_STEPS(MARCH_STEPS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_data(b_data), .q_valid(b_valid), .q_ready(b_ready),
    .res(res), .res_valid(res_valid), .res_ready(res_ready)
  );

  // output register
  assign res_ready = !out_v_r || out_m.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_ready) begin
      out_v_r <= res_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_m.valid      = out_v_r;
  assign out_m.column     = out_r.column;
  assign out_m.wall_hit   = out_r.wall_hit;
  assign out_m.side       = out_r.side;
  assign out_m.distance   = out_r.distance;
  assign out_m.span_start = out_r.span_start;
  assign out_m.span_end   = out_r.span_end;
  assign out_m.red        = out_r.red;
  assign out_m.green      = out_r.green;
  assign out_m.blue       = out_r.blue;
endmodule

FILE: tb/sv/tb.sv
// Testbench for raycast_column_renderer: loads wall maps, casts columns and checks
// every result beat against a bit-accurate predictor. Depends on rcr_pkg and rcr_if.
module tb;
  import rcr_pkg::*;

  localparam int ROWS       = 480;
  localparam int STEPS      = 4096;
  localparam int CELLS      = 16;
  localparam int CYCLE_MAX  = 6000000;
  localparam int SETTLE     = 4400;
  localparam int HOLD_LEN   = 30000;
  localparam int COLS_MAX   = 1023;

  logic clk;
  logic rst_n;

  rcr_in_if  in_if();
  rcr_out_if out_if();
  rcr_cfg_if cfg_if();

  raycast_column_renderer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if),
    .cfg_s (cfg_if)
  );

  // Predictor state: viewer and map as the block should hold them
  logic [15:0] mdl_pos_x, mdl_pos_y;
  logic [11:0] mdl_view;
  logic [15:0] mdl_map [CELLS];

  cmd_t    pending_cmds[$];
  result_t expected_cols[$];
  int      mismatches;
  int      idle_mode;     // 0: sender light/receiver heavy, 1: swapped, 2: none
  logic    hold_go;
  int      hold_left;
  int      cycles;

  // Q1.14 sine of a quarter-turn fraction t/1024
  function automatic longint quarter_sin(longint unsigned t);
    longint unsigned t2, inner, mid;
    t2    = (t * t) >> 10;
    inner = SIN_C3 - ((t2 * SIN_C5) >> 10);
    mid   = SIN_C1 - ((t2 * inner) >> 10);
    return longint'((t * mid) >> 10);
  endfunction

  function automatic longint sin_q14(longint unsigned a);
    longint unsigned q, r;
    longint v;
    a = a & 4095;
    q = a >> 10;
    r = a & 1023;
    v = q[0] ? quarter_sin(1024 - r) : quarter_sin(r);
    return (q >= 2) ? -v : v;
  endfunction

  function automatic longint cos_q14(longint unsigned a);
    return sin_q14(a + 1024);
  endfunction

  function automatic bit cell_blocked(longint rx, longint ry);
    longint unsigned cx, cy;
    if (rx < 0 || ry < 0) return 1'b1;
    cx = longint'(rx) >>> 26;
    cy = longint'(ry) >>> 26;
    if (cx >= CELLS || cy >= CELLS) return 1'b1;
    return mdl_map[cy][cx];
  endfunction

  // March one ray and build the expected column
  function automatic result_t render_column(cmd_t c);
    result_t res;
    longint step, dx, dy, rx, ry, march_len, prod, h, start, stop;
    longint unsigned d, frac, cr, cg, cb;
    bit hit, side;
    step = RANGE_Q12 / STEPS;
    dx = cos_q14(c.angle) * step;
    dy = sin_q14(c.angle) * step;
    rx = longint'(mdl_pos_x) <<< 14;
    ry = longint'(mdl_pos_y) <<< 14;
    march_len = 0;
    hit = 0;
    side = 0;
    for (int k = 0; k < STEPS; k++) begin
      rx += dx;
      ry += dy;
      march_len += step;
      if (cell_blocked(rx, ry)) begin
        hit = 1;
        frac = (rx < 0) ? 0 : ((rx & 64'h3FFFFFF) >> 14);
        side = (frac < FRAC_LOW || frac > FRAC_HIGH);
        break;
      end
    end
    prod = march_len * cos_q14((longint'(c.angle) - longint'(mdl_view) + 4096) & 4095);
    d = (prod <= 0) ? 0 : longint'(prod >>> 14);
    h = longint'((longint'(ROWS) * SPAN_SCALE) / (d + EPS_Q12));
    start = (ROWS - h) / 2;
    stop = start + h;
    if (start < 0) start = 0;
    if (stop >= ROWS) stop = ROWS - 1;
    if (!side) begin
      cr = COL_R0; cg = COL_G0; cb = COL_G0;
    end else begin
      cr = COL_R1; cg = COL_G1; cb = COL_G1;
    end
    res.column     = c.column;
    res.wall_hit   = hit;
    res.side       = side;
    res.distance   = d[16:0];
    res.span_start = start[8:0];
    res.span_end   = stop[8:0];
    res.red        = 8'((cr * SHADE_DEN) / (SHADE_DEN + d));
    res.green      = 8'((cg * SHADE_DEN) / (SHADE_DEN + d));
    res.blue       = 8'((cb * SHADE_DEN) / (SHADE_DEN + d));
    return res;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("tb failed");
      $finish;
    end
  end

  // Input driver: one beat per accepted item, predicts on acceptance
  always @(posedge clk) begin
    int roll;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (pending_cmds[0].is_cast)
          expected_cols.push_back(render_column(pending_cmds[0]));
        else
          mdl_map[pending_cmds[0].row] = pending_cmds[0].bits;
        void'(pending_cmds.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        roll = $urandom_range(99);
        if (pending_cmds.size() != 0 &&
            !((idle_mode == 0 && roll < 14) || (idle_mode == 1 && roll < 82))) begin
          in_if.valid      <= 1'b1;
          in_if.opcode     <= pending_cmds[0].is_cast;
          in_if.row_index  <= pending_cmds[0].row;
          in_if.row_bits   <= pending_cmds[0].bits;
          in_if.column     <= pending_cmds[0].column;
          in_if.cast_angle <= pending_cmds[0].angle;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_go && hold_left == 0) begin
      hold_left <= HOLD_LEN;
      hold_go   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    int roll;
    result_t got, want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.column, out_if.wall_hit, out_if.side, out_if.distance,
                out_if.span_start, out_if.span_end, out_if.red, out_if.green, out_if.blue};
        if (expected_cols.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected column beat %p", got);
        end else begin
          want = expected_cols.pop_front();
          if (got.column != want.column || got.wall_hit != want.wall_hit ||
              got.side != want.side || got.distance != want.distance ||
              got.span_start != want.span_start || got.span_end != want.span_end ||
              got.red != want.red || got.green != want.green || got.blue != want.blue) begin
            mismatches++;
            if (mismatches <= 10) $display("column mismatch: exp %p got %p", want, got);
          end
        end
      end
      roll = $urandom_range(99);
      out_if.ready <= (hold_left == 0) &&
                      !((idle_mode == 0 && roll < 82) || (idle_mode == 1 && roll < 14));
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_POS_X:      mdl_pos_x = data;
      CFG_POS_Y:      mdl_pos_y = data;
      CFG_VIEW_ANGLE: mdl_view  = data[11:0];
      default: ;
    endcase
  endtask

  task automatic set_viewer(logic [15:0] x, logic [15:0] y, logic [11:0] a);
    cfg_write(CFG_POS_X, x);
    cfg_write(CFG_POS_Y, y);
    cfg_write(CFG_VIEW_ANGLE, {4'd0, a});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_row(logic [3:0] r, logic [15:0] b);
    cmd_t c;
    c.is_cast = OP_WRITE_ROW;
    c.row     = r;
    c.bits    = b;
    c.column  = 10'($urandom);
    c.angle   = 12'($urandom);
    pending_cmds.push_back(c);
  endtask

  task automatic push_cast(logic [9:0] col, logic [11:0] a);
    cmd_t c;
    c.is_cast = OP_CAST;
    c.row     = 4'($urandom);
    c.bits    = 16'($urandom);
    c.column  = col;
    c.angle   = a;
    pending_cmds.push_back(c);
  endtask

  // Wait for the block to go quiet before touching config
  task automatic drain();
    while (pending_cmds.size() != 0 || expected_cols.size() != 0 || hold_left != 0 || hold_go)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random mix: mostly casts into sparse maps, some dense row noise
  task automatic random_items(int n);
    logic [15:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 28) begin
        b = 16'($urandom) & 16'($urandom) & 16'($urandom);
        if ($urandom_range(3) == 0) b = 16'($urandom);
        push_row(4'($urandom), b);
      end else begin
        push_cast(10'($urandom_range(COLS_MAX)), 12'($urandom));
      end
    end
  endtask

  initial begin
    mismatches   = 0;
    cycles       = 0;
    idle_mode    = 0;
    hold_go      = 1'b0;
    hold_left    = 0;
    mdl_pos_x    = '0;
    mdl_pos_y    = '0;
    mdl_view     = '0;
    in_if.valid  = 1'b0;
    in_if.opcode = 1'b0;
    in_if.row_index  = '0;
    in_if.row_bits   = '0;
    in_if.column     = '0;
    in_if.cast_angle = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.idx   = CFG_POS_X;
    cfg_if.data  = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bordered room with a few pillars, viewer near center
    set_viewer(16'h8800, 16'h8800, 12'd0);
    push_row(4'd0, 16'hFFFF);
    for (int r = 1; r < 15; r++) push_row(4'(r), (r == 5) ? 16'h8C31 : 16'h8001);
    push_row(4'd15, 16'hFFFF);
    push_cast(10'd0, 12'd0);
    push_cast(10'd639, 12'd1024);
    push_cast(10'd1023, 12'd2048);
    push_cast(10'd320, 12'd3072);
    push_cast(10'd1, 12'd4095);
    push_cast(10'd2, 12'd512);
    drain();

    // Empty map from the origin corner: diagonal ray misses, others leave the map
    set_viewer(16'h0000, 16'h0000, 12'd4095);
    for (int r = 0; r < 16; r++) push_row(4'(r), 16'h0000);
    push_cast(10'd10, 12'd512);
    push_cast(10'd11, 12'd2048);
    push_cast(10'd12, 12'd0);
    drain();

    // Random, sender light idling and receiver heavy
    set_viewer(16'($urandom_range(4096, 61439)), 16'($urandom_range(4096, 61439)),
               12'($urandom));
    random_items(30);
    drain();

    // Far corner, swapped idling, long receiver hold-off
    idle_mode = 1;
    set_viewer(16'hFFFF, 16'hFFFF, 12'd2048);
    hold_go = 1'b1;
    random_items(30);
    drain();

    // Random viewer, no idling
    idle_mode = 2;
    set_viewer(16'($urandom), 16'($urandom), 12'($urandom));
    random_items(40);
    drain();

    if (mismatches == 0 && expected_cols.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: raycast_column_renderer.f
rtl/rcr_pkg.sv
rtl/rcr_if.sv
rtl/rcr_front.sv
rtl/rcr_fifo.sv
rtl/rcr_div.sv
rtl/rcr_back.sv
rtl/raycast_column_renderer.sv
tb/sv/tb.sv
